/* design/bfdh_pkg.sv */
// ----------------------------------------------------------------------------
// bfdh_pkg
// Shared constants, codes and helpers for the double-hashing Bloom filter.
// ----------------------------------------------------------------------------
`default_nettype none

package bfdh_pkg;

  // Default sizing of the filter and of the key.
  localparam int DEF_MAX_FILTER_BITS = 1048576;
  localparam int DEF_KEY_BYTES       = 24;

  // Port widths.
  localparam int IN_TDATA_W  = 256;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 21;
  localparam int NH_W        = 8;
  localparam int FB_W        = 21;
  localparam int CNT_W       = 32;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_HASHES  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_BITS = 1'b1;

  // Register reset values.
  localparam logic [NH_W-1:0] NH_RESET = 8'd7;
  localparam logic [FB_W-1:0] FB_RESET = 21'd1048576;

  // Command codes carried on in_tuser.
  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Saturation value of the add counter.
  localparam logic [CNT_W-1:0] CNT_MAX = 32'hFFFF_FFFF;

  // MurmurHash3 x64 128-bit constants.
  localparam logic [63:0] MIX_C1  = 64'h87c3_7b91_1142_53d5;
  localparam logic [63:0] MIX_C2  = 64'h4cf5_ad43_2745_937f;
  localparam logic [63:0] FMIX_M1 = 64'hff51_afd7_ed55_8ccd;
  localparam logic [63:0] FMIX_M2 = 64'hc4ce_b9fe_1a85_ec53;
  localparam logic [63:0] H1_ADD  = 64'h0000_0000_52dc_e729;
  localparam logic [63:0] H2_ADD  = 64'h0000_0000_3849_5ab5;

  // Rotate left by a constant amount.
  function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned r);
    return (x << r) | (x >> (64 - r));
  endfunction

endpackage

`default_nettype wire

/* design/bfdh_mul64.sv */
// ----------------------------------------------------------------------------
// bfdh_mul64
// 64 x 64 multiplier keeping the low 64 bits, built on one 32 x 32 multiplier
// that is used in turn for each partial product.
// ----------------------------------------------------------------------------
`default_nettype none

module bfdh_mul64 (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic             done,
  output logic [63:0]      p
);

  logic [63:0] a_r;
  logic [63:0] b_r;
  logic [63:0] acc_r;
  logic [1:0]  step_r;
  logic        busy_r;
  logic        done_r;
  logic [31:0] op_x;
  logic [31:0] op_y;
  logic [63:0] prod;

  // Partial products: lo*lo, then lo*hi and hi*lo into the upper half.
  always_comb begin
    op_x = (step_r == 2'd2) ? a_r[63:32] : a_r[31:0];
    op_y = (step_r == 2'd1) ? b_r[63:32] : b_r[31:0];
    prod = op_x * op_y;
  end

  // Control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= 2'd0;
      end else if (busy_r) begin
        if (step_r == 2'd2) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        step_r <= step_r + 2'd1;
      end
    end
  end

  // Operands and accumulator.
  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
    end
    if (busy_r) begin
      if (step_r == 2'd0) begin
        acc_r <= prod;
      end else begin
        acc_r <= acc_r + {prod[31:0], 32'h0};
      end
    end
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule

`default_nettype wire

/* design/bfdh_hash.sv */
// ----------------------------------------------------------------------------
// bfdh_hash
// MurmurHash3 x64 128-bit, seed 0, over a fixed-length key, sequenced around
// one shared 64-bit multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module bfdh_hash #(
  parameter int KEY_BYTES = bfdh_pkg::DEF_KEY_BYTES
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [3:0][63:0] key,
  output logic                  done,
  output logic [63:0]           ha,
  output logic [63:0]           hb
);

  localparam int BLOCKS = KEY_BYTES / 16;
  localparam int REMB   = KEY_BYTES % 16;
  localparam logic [1:0] NBLK      = 2'(BLOCKS);
  localparam logic [1:0] TAIL_LO   = 2'((2 * BLOCKS) % 4);
  localparam logic [1:0] TAIL_HI   = 2'((2 * BLOCKS + 1) % 4);
  localparam logic [63:0] LEN64    = 64'(KEY_BYTES);
  localparam logic [255:0] KEY_MASK = (KEY_BYTES >= 32) ? {256{1'b1}} :
                                      ((256'd1 << (8 * KEY_BYTES)) - 256'd1);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_DISP = 5'd1;
  localparam logic [4:0] S_MW   = 5'd2;
  localparam logic [4:0] S_K1R  = 5'd3;
  localparam logic [4:0] S_K1X  = 5'd4;
  localparam logic [4:0] S_H1M  = 5'd5;
  localparam logic [4:0] S_K2R  = 5'd6;
  localparam logic [4:0] S_K2X  = 5'd7;
  localparam logic [4:0] S_H2M  = 5'd8;
  localparam logic [4:0] S_T2R  = 5'd9;
  localparam logic [4:0] S_T2X  = 5'd10;
  localparam logic [4:0] S_T1R  = 5'd11;
  localparam logic [4:0] S_T1X  = 5'd12;
  localparam logic [4:0] S_FIN1 = 5'd13;
  localparam logic [4:0] S_FIN2 = 5'd14;
  localparam logic [4:0] S_FMA  = 5'd15;
  localparam logic [4:0] S_FMB  = 5'd16;
  localparam logic [4:0] S_FMC  = 5'd17;
  localparam logic [4:0] S_FIN3 = 5'd18;
  localparam logic [4:0] S_FIN4 = 5'd19;

  logic [4:0]       state_r, state_nxt;
  logic [4:0]       ret_r, ret_nxt;
  logic [63:0]      h1_r, h1_nxt;
  logic [63:0]      h2_r, h2_nxt;
  logic [1:0]       blk_r, blk_nxt;
  logic             ftgt_r, ftgt_nxt;
  logic             done_r, done_nxt;
  logic [3:0][63:0] key_r;
  logic             mstart;
  logic [63:0]      ma;
  logic [63:0]      mb;
  logic             mdone;
  logic [63:0]      mp;
  logic [63:0]      pm;
  logic [63:0]      fx;

  bfdh_mul64 u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mstart),
    .a     (ma),
    .b     (mb),
    .done  (mdone),
    .p     (mp)
  );

  // Sequencer: each multiply parks in S_MW and returns to ret_r.
  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    h1_nxt    = h1_r;
    h2_nxt    = h2_r;
    blk_nxt   = blk_r;
    ftgt_nxt  = ftgt_r;
    done_nxt  = 1'b0;
    mstart    = 1'b0;
    ma        = 64'h0;
    mb        = 64'h0;
    pm        = mp ^ (mp >> 33);
    fx        = ftgt_r ? h2_r : h1_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          h1_nxt    = 64'h0;
          h2_nxt    = 64'h0;
          blk_nxt   = 2'd0;
          ftgt_nxt  = 1'b0;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (blk_r < NBLK) begin
          mstart = 1'b1; ma = key_r[{blk_r[0], 1'b0}]; mb = bfdh_pkg::MIX_C1;
          ret_nxt = S_K1R; state_nxt = S_MW;
        end else if (REMB > 8) begin
          mstart = 1'b1; ma = key_r[TAIL_HI]; mb = bfdh_pkg::MIX_C2;
          ret_nxt = S_T2R; state_nxt = S_MW;
        end else if (REMB > 0) begin
          mstart = 1'b1; ma = key_r[TAIL_LO]; mb = bfdh_pkg::MIX_C1;
          ret_nxt = S_T1R; state_nxt = S_MW;
        end else begin
          state_nxt = S_FIN1;
        end
      end
      S_MW: begin
        if (mdone) begin
          state_nxt = ret_r;
        end
      end
      S_K1R: begin
        mstart = 1'b1; ma = bfdh_pkg::rotl64(mp, 31); mb = bfdh_pkg::MIX_C2;
        ret_nxt = S_K1X; state_nxt = S_MW;
      end
      S_K1X: begin
        h1_nxt    = bfdh_pkg::rotl64(h1_r ^ mp, 27) + h2_r;
        state_nxt = S_H1M;
      end
      S_H1M: begin
        h1_nxt = (h1_r << 2) + h1_r + bfdh_pkg::H1_ADD;
        mstart = 1'b1; ma = key_r[{blk_r[0], 1'b1}]; mb = bfdh_pkg::MIX_C2;
        ret_nxt = S_K2R; state_nxt = S_MW;
      end
      S_K2R: begin
        mstart = 1'b1; ma = bfdh_pkg::rotl64(mp, 33); mb = bfdh_pkg::MIX_C1;
        ret_nxt = S_K2X; state_nxt = S_MW;
      end
      S_K2X: begin
        h2_nxt    = bfdh_pkg::rotl64(h2_r ^ mp, 31) + h1_r;
        state_nxt = S_H2M;
      end
      S_H2M: begin
        h2_nxt    = (h2_r << 2) + h2_r + bfdh_pkg::H2_ADD;
        blk_nxt   = blk_r + 2'd1;
        state_nxt = S_DISP;
      end
      S_T2R: begin
        mstart = 1'b1; ma = bfdh_pkg::rotl64(mp, 33); mb = bfdh_pkg::MIX_C1;
        ret_nxt = S_T2X; state_nxt = S_MW;
      end
      S_T2X: begin
        h2_nxt = h2_r ^ mp;
        mstart = 1'b1; ma = key_r[TAIL_LO]; mb = bfdh_pkg::MIX_C1;
        ret_nxt = S_T1R; state_nxt = S_MW;
      end
      S_T1R: begin
        mstart = 1'b1; ma = bfdh_pkg::rotl64(mp, 31); mb = bfdh_pkg::MIX_C2;
        ret_nxt = S_T1X; state_nxt = S_MW;
      end
      S_T1X: begin
        h1_nxt    = h1_r ^ mp;
        state_nxt = S_FIN1;
      end
      S_FIN1: begin
        h1_nxt    = (h1_r ^ LEN64) + (h2_r ^ LEN64);
        h2_nxt    = h2_r ^ LEN64;
        state_nxt = S_FIN2;
      end
      S_FIN2: begin
        h2_nxt    = h2_r + h1_r;
        ftgt_nxt  = 1'b0;
        state_nxt = S_FMA;
      end
      S_FMA: begin
        mstart = 1'b1; ma = fx ^ (fx >> 33); mb = bfdh_pkg::FMIX_M1;
        ret_nxt = S_FMB; state_nxt = S_MW;
      end
      S_FMB: begin
        mstart = 1'b1; ma = pm; mb = bfdh_pkg::FMIX_M2;
        ret_nxt = S_FMC; state_nxt = S_MW;
      end
      S_FMC: begin
        if (ftgt_r) begin
          h2_nxt    = pm;
          state_nxt = S_FIN3;
        end else begin
          h1_nxt    = pm;
          ftgt_nxt  = 1'b1;
          state_nxt = S_FMA;
        end
      end
      S_FIN3: begin
        h1_nxt    = h1_r + h2_r;
        state_nxt = S_FIN4;
      end
      S_FIN4: begin
        h2_nxt    = h2_r + h1_r;
        done_nxt  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
      blk_r   <= 2'd0;
      ftgt_r  <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      blk_r   <= blk_nxt;
      ftgt_r  <= ftgt_nxt;
      done_r  <= done_nxt;
    end
  end

  // Hash state and key; bytes past the key length are zeroed on capture.
  always_ff @(posedge clk) begin
    h1_r <= h1_nxt;
    h2_r <= h2_nxt;
    if (start && (state_r == S_IDLE)) begin
      key_r <= key & KEY_MASK;
    end
  end

  assign done = done_r;
  assign ha   = h1_r;
  assign hb   = h2_r;

endmodule

`default_nettype wire

/* design/bfdh_rem.sv */
// ----------------------------------------------------------------------------
// bfdh_rem
// Three-lane restoring remainder unit: A mod size, B mod size and 2^64 mod
// size, one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bfdh_rem #(
  parameter int SW = 21
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [63:0]   ha,
  input  wire logic [63:0]   hb,
  input  wire logic [SW-1:0] size,
  output logic               done,
  output logic [SW-1:0]      a_mod,
  output logic [SW-1:0]      b_mod,
  output logic [SW-1:0]      w_mod
);

  logic [63:0]   dv_r [3];
  logic [SW-1:0] rm_r [3];
  logic [SW-1:0] rm_nxt [3];
  logic [5:0]    cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [SW:0]   sh [3];
  logic [SW:0]   w_inc;

  // One restoring step per lane.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sh[i] = {rm_r[i], dv_r[i][63]};
      if (sh[i] >= {1'b0, size}) begin
        rm_nxt[i] = SW'(sh[i] - {1'b0, size});
      end else begin
        rm_nxt[i] = SW'(sh[i]);
      end
    end
  end

  // Control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Dividends and partial remainders; lane 2 divides 2^64 - 1.
  always_ff @(posedge clk) begin
    if (start) begin
      dv_r[0] <= ha;
      dv_r[1] <= hb;
      dv_r[2] <= {64{1'b1}};
      for (int i = 0; i < 3; i++) begin
        rm_r[i] <= '0;
      end
    end else if (busy_r) begin
      for (int i = 0; i < 3; i++) begin
        dv_r[i] <= {dv_r[i][62:0], 1'b0};
        rm_r[i] <= rm_nxt[i];
      end
    end
  end

  // 2^64 mod size = ((2^64 - 1) mod size + 1) mod size.
  always_comb begin
    w_inc = {1'b0, rm_r[2]} + {{SW{1'b0}}, 1'b1};
    w_mod = (w_inc == {1'b0, size}) ? '0 : SW'(w_inc);
  end

  assign done  = done_r;
  assign a_mod = rm_r[0];
  assign b_mod = rm_r[1];

endmodule

`default_nettype wire

/* design/bloom_filter_double_hash.sv */
// ----------------------------------------------------------------------------
// bloom_filter_double_hash
// Bloom filter with MurmurHash3 x64 128-bit double hashing over a one-bit
// synchronous store.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake            Contents
//  in_      slave      in_tvalid/in_tready  tdata key words, tuser command
//  out_     master     out_tvalid/out_tready tdata presence flag, add count
//  cfg_     slave      cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  One word at a time. The key is hashed first (each 64-bit multiply runs on
//  a shared 32 x 32 multiplier), then the three remainders are found, then
//  the store is probed once per cycle, and last come the final read, the
//  output load, which waits while the output is stalled, and the next accept.
//  After reset the store is cleared one bit a cycle while in_tready stays low;
//  configuration writes are taken at all times.
//  A finished result waits in the output register while the next word is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module bloom_filter_double_hash #(
  parameter int MAX_FILTER_BITS = bfdh_pkg::DEF_MAX_FILTER_BITS,
  parameter int KEY_BYTES       = bfdh_pkg::DEF_KEY_BYTES
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // key_word0 [63:0], key_word1 [127:64], key_word2 [191:128], key_word3 [255:192]
  input  wire logic [bfdh_pkg::IN_TDATA_W-1:0]  in_tdata,
  // cmd [0]
  input  wire logic                             in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // possibly_present [0], items_added [32:1], zero [39:33]
  output logic [bfdh_pkg::OUT_TDATA_W-1:0]      out_tdata,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [bfdh_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [bfdh_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = $clog2(MAX_FILTER_BITS);
  localparam int SW = $clog2(MAX_FILTER_BITS + 1);
  localparam int CW = (SW > bfdh_pkg::FB_W) ? SW : bfdh_pkg::FB_W;
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_FILTER_BITS - 1);
  localparam logic [CW-1:0] MAX_C     = CW'(MAX_FILTER_BITS);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_HASH  = 3'd2;
  localparam logic [2:0] ST_REM   = 3'd3;
  localparam logic [2:0] ST_PROBE = 3'd4;
  localparam logic [2:0] ST_LAST  = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0]                    state_r;
  logic [bfdh_pkg::NH_W-1:0]     nh_r;
  logic [bfdh_pkg::FB_W-1:0]     fb_r;
  logic [AW-1:0]                 clr_addr_r;
  logic                          cmd_r;
  logic [SW-1:0]                 r_r;
  logic [SW-1:0]                 bm_r;
  logic [SW-1:0]                 wm_r;
  logic [63:0]                   x_r;
  logic [bfdh_pkg::NH_W-1:0]     n_r;
  logic                          rd_vld_r;
  logic                          present_r;
  logic [bfdh_pkg::CNT_W-1:0]    cnt_r;
  logic [bfdh_pkg::CNT_W-1:0]    cnt_nxt;
  logic                          out_tvalid_r;
  logic [bfdh_pkg::OUT_TDATA_W-1:0] out_tdata_r;

  logic                          store_mem [MAX_FILTER_BITS];
  logic                          mem_q_r;
  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  logic                          mem_wd;

  logic                          in_acc;
  logic                          hash_done;
  logic [63:0]                   hash_ha;
  logic [63:0]                   hash_hb;
  logic                          rem_done;
  logic [SW-1:0]                 a_mod;
  logic [SW-1:0]                 b_mod;
  logic [SW-1:0]                 w_mod;
  logic [CW-1:0]                 fb_ext;
  logic [SW-1:0]                 size;
  logic                          issue;
  logic                          out_load;
  logic [64:0]                   x_sum;
  logic [SW:0]                   r_add;
  logic [SW-1:0]                 r_mod;
  logic [SW:0]                   r_wrap;
  logic [SW-1:0]                 r_next;

  // Effective filter size: zero counts as one, clamped to the store depth.
  always_comb begin
    fb_ext = CW'(fb_r);
    if (fb_r == '0) begin
      size = SW'(1);
    end else if (fb_ext > MAX_C) begin
      size = SW'(MAX_C);
    end else begin
      size = SW'(fb_ext);
    end
  end

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  bfdh_hash #(
    .KEY_BYTES (KEY_BYTES)
  ) u_hash (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc),
    .key   (in_tdata),
    .done  (hash_done),
    .ha    (hash_ha),
    .hb    (hash_hb)
  );

  bfdh_rem #(
    .SW (SW)
  ) u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .start (hash_done),
    .ha    (hash_ha),
    .hb    (hash_hb),
    .size  (size),
    .done  (rem_done),
    .a_mod (a_mod),
    .b_mod (b_mod),
    .w_mod (w_mod)
  );

  // Next probe residue: add B mod size, and take back 2^64 mod size when
  // the 64-bit running sum wraps.
  always_comb begin
    x_sum = {1'b0, x_r} + {1'b0, hash_hb};
    r_add = {1'b0, r_r} + {1'b0, bm_r};
    r_mod = (r_add >= {1'b0, size}) ? SW'(r_add - {1'b0, size}) : SW'(r_add);
    if (r_mod >= wm_r) begin
      r_wrap = {1'b0, r_mod} - {1'b0, wm_r};
    end else begin
      r_wrap = {1'b0, r_mod} + {1'b0, size} - {1'b0, wm_r};
    end
    r_next = x_sum[64] ? SW'(r_wrap) : r_mod;
  end

  assign issue    = (state_r == ST_PROBE) && (n_r != nh_r);
  assign out_load = (state_r == ST_DONE) && (!out_tvalid_r || out_tready);

  // Store write port: clearing pass, or add probes setting bits.
  always_comb begin
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wd    = 1'b0;
    end else begin
      mem_we    = issue && (cmd_r == bfdh_pkg::CMD_ADD);
      mem_waddr = r_r[AW-1:0];
      mem_wd    = 1'b1;
    end
  end

  // Bit store with registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[mem_waddr] <= mem_wd;
    end
    mem_q_r <= store_mem[r_r[AW-1:0]];
  end

  // Saturating add count after this word.
  always_comb begin
    if ((cmd_r == bfdh_pkg::CMD_ADD) && (cnt_r != bfdh_pkg::CNT_MAX)) begin
      cnt_nxt = cnt_r + 32'd1;
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  // Main sequencer and control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_addr_r   <= '0;
      nh_r         <= bfdh_pkg::NH_RESET;
      fb_r         <= bfdh_pkg::FB_RESET;
      cnt_r        <= '0;
      out_tvalid_r <= 1'b0;
      rd_vld_r     <= 1'b0;
      n_r          <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bfdh_pkg::CFG_NUM_HASHES:  nh_r <= cfg_data[bfdh_pkg::NH_W-1:0];
          bfdh_pkg::CFG_FILTER_BITS: fb_r <= cfg_data[bfdh_pkg::FB_W-1:0];
          default: begin
          end
        endcase
      end
      rd_vld_r <= issue && (cmd_r == bfdh_pkg::CMD_QUERY);
      if (out_load) begin
        out_tvalid_r <= 1'b1;
        cnt_r        <= cnt_nxt;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: begin
          clr_addr_r <= clr_addr_r + AW'(1);
          if (clr_addr_r == LAST_ADDR) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            state_r <= ST_HASH;
          end
        end
        ST_HASH: begin
          if (hash_done) begin
            state_r <= ST_REM;
          end
        end
        ST_REM: begin
          if (rem_done) begin
            n_r     <= '0;
            state_r <= ST_PROBE;
          end
        end
        ST_PROBE: begin
          if (issue) begin
            n_r <= n_r + 8'd1;
          end else begin
            state_r <= ST_LAST;
          end
        end
        ST_LAST: begin
          state_r <= ST_DONE;
        end
        ST_DONE: begin
          if (out_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Per-word payload: command, probe walk and query result.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r <= in_tuser;
    end
    if ((state_r == ST_REM) && rem_done) begin
      r_r       <= a_mod;
      bm_r      <= b_mod;
      wm_r      <= w_mod;
      x_r       <= hash_ha;
      present_r <= 1'b1;
    end else begin
      if (issue) begin
        r_r <= r_next;
        x_r <= x_sum[63:0];
      end
      if (rd_vld_r && !mem_q_r) begin
        present_r <= 1'b0;
      end
    end
    if (out_load) begin
      out_tdata_r <= {7'd0, cnt_nxt,
                      (cmd_r == bfdh_pkg::CMD_QUERY) && present_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

`default_nettype wire

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// Bloom filter testbench
// Drives add and query words into the double-hashing Bloom filter under
// several filter sizes, probe counts and flow-control patterns. A scoreboard
// keeps its own copy of the bit store and the add counter, hashes each key
// and compares every result word with its prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  localparam int MAX_BITS     = bfdh_pkg::DEF_MAX_FILTER_BITS;
  localparam int SETTLE_CYC   = 450;
  localparam int WATCHDOG_CYC = 4_200_000;

  // Expected contents of one result word.
  typedef struct {
    logic                       present;
    logic [bfdh_pkg::CNT_W-1:0] count;
  } filter_answer_t;

  // Tracks the filter state and checks result words in order.
  class bloom_scoreboard;
    bit                         filter_store[];
    logic [bfdh_pkg::CNT_W-1:0] add_count;
    logic [bfdh_pkg::NH_W-1:0]  probes;
    logic [bfdh_pkg::FB_W-1:0]  size_reg;
    filter_answer_t             pending_answers[$];
    int                         fail_count;
    int                         checked;
    int                         hits;

    function new();
      filter_store = new[MAX_BITS];
      add_count    = '0;
      probes       = bfdh_pkg::NH_RESET;
      size_reg     = bfdh_pkg::FB_RESET;
      fail_count   = 0;
      checked      = 0;
      hits         = 0;
    endfunction

    function void write_reg(logic [bfdh_pkg::CFG_IDX_W-1:0] idx,
                            logic [bfdh_pkg::CFG_DATA_W-1:0] val);
      if (idx == bfdh_pkg::CFG_NUM_HASHES) probes = val[bfdh_pkg::NH_W-1:0];
      else size_reg = val[bfdh_pkg::FB_W-1:0];
    endfunction

    function logic [63:0] rol(logic [63:0] x, int r);
      return (x << r) | (x >> (64 - r));
    endfunction

    function logic [63:0] avalanche(logic [63:0] k);
      k = k ^ (k >> 33);
      k = k * bfdh_pkg::FMIX_M1;
      k = k ^ (k >> 33);
      k = k * bfdh_pkg::FMIX_M2;
      return k ^ (k >> 33);
    endfunction

    // MurmurHash3 x64 128 over a 24-byte key: one full block plus an 8-byte tail.
    function void murmur_halves(logic [255:0] key, output logic [63:0] a, output logic [63:0] b);
      logic [63:0] h1, h2, k1, k2;
      h1 = '0;
      h2 = '0;
      k1 = key[63:0] * bfdh_pkg::MIX_C1;
      k1 = rol(k1, 31) * bfdh_pkg::MIX_C2;
      h1 = rol(h1 ^ k1, 27) + h2;
      h1 = h1 * 64'd5 + bfdh_pkg::H1_ADD;
      k2 = key[127:64] * bfdh_pkg::MIX_C2;
      k2 = rol(k2, 33) * bfdh_pkg::MIX_C1;
      h2 = rol(h2 ^ k2, 31) + h1;
      h2 = h2 * 64'd5 + bfdh_pkg::H2_ADD;
      k1 = key[191:128] * bfdh_pkg::MIX_C1;
      k1 = rol(k1, 31) * bfdh_pkg::MIX_C2;
      h1 = h1 ^ k1;
      h1 = h1 ^ 64'd24;
      h2 = h2 ^ 64'd24;
      h1 = h1 + h2;
      h2 = h2 + h1;
      h1 = avalanche(h1);
      h2 = avalanche(h2);
      h1 = h1 + h2;
      h2 = h2 + h1;
      a = h1;
      b = h2;
    endfunction

    // Applies one accepted word to the model and queues its answer.
    function void note_word(logic cmd, logic [255:0] key);
      logic [63:0] ha, hb, span, pos;
      filter_answer_t ans;
      murmur_halves(key, ha, hb);
      span = (size_reg == 0) ? 64'd1 : 64'(size_reg);
      if (span > 64'(MAX_BITS)) span = 64'(MAX_BITS);
      ans.present = (cmd == bfdh_pkg::CMD_QUERY);
      for (int n = 0; n < probes; n++) begin
        pos = (ha + 64'(n) * hb) % span;
        if (cmd == bfdh_pkg::CMD_QUERY) begin
          if (!filter_store[pos]) begin
            ans.present = 1'b0;
            break;
          end
        end else begin
          filter_store[pos] = 1'b1;
        end
      end
      if (cmd == bfdh_pkg::CMD_ADD && add_count != bfdh_pkg::CNT_MAX) add_count++;
      ans.count = add_count;
      pending_answers.push_back(ans);
    endfunction

    function void check_word(logic [bfdh_pkg::OUT_TDATA_W-1:0] data);
      filter_answer_t ans;
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result word %h", $time, data);
        fail_count++;
        return;
      end
      ans = pending_answers.pop_front();
      checked++;
      if (data[0]) hits++;
      if (data[0] !== ans.present) begin
        $display("%0t: possibly_present expected %0d actual %0d", $time, ans.present, data[0]);
        fail_count++;
      end
      if (data[32:1] !== ans.count) begin
        $display("%0t: items_added expected %0d actual %0d", $time, ans.count, data[32:1]);
        fail_count++;
      end
    endfunction
  endclass

  logic                                 clk = 1'b0;
  logic                                 rst_n = 1'b0;
  logic                                 in_tvalid = 1'b0;
  logic                                 in_tready;
  logic [bfdh_pkg::IN_TDATA_W-1:0]      in_tdata = '0;
  logic                                 in_tuser = 1'b0;
  logic                                 out_tvalid;
  logic                                 out_tready = 1'b0;
  logic [bfdh_pkg::OUT_TDATA_W-1:0]     out_tdata;
  logic                                 cfg_valid = 1'b0;
  logic                                 cfg_ready;
  logic [bfdh_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
  logic [bfdh_pkg::CFG_DATA_W-1:0]      cfg_data = '0;

  bloom_scoreboard sb = new();
  logic [255:0]    added_keys[$];
  int              idle_pct = 0;
  int              stall_pct = 0;
  int              quiet_cycles = 0;

  bloom_filter_double_hash u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // The result side stalls at random.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Result words are checked as they are taken.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_word(out_tdata);
  end

  // The watchdog counts cycles without any handshake.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_CYC) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [bfdh_pkg::CFG_IDX_W-1:0] idx,
                           logic [bfdh_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Sends one word; valid stays high into the next call unless a gap is drawn.
  task automatic send_word(logic cmd, logic [255:0] key);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= key;
    in_tuser  <= cmd;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_word(cmd, key);
    if (cmd == bfdh_pkg::CMD_ADD) added_keys.push_back(key);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending_answers.size() != 0) @(posedge clk);
  endtask

  function automatic logic [255:0] random_key();
    return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  // A mix of adds and queries of known keys, with some unseen queries.
  task automatic random_words(int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 40 || added_keys.size() == 0)
        send_word(bfdh_pkg::CMD_ADD, random_key());
      else if (pick < 80)
        send_word(bfdh_pkg::CMD_QUERY, added_keys[$urandom_range(added_keys.size() - 1)]);
      else
        send_word(bfdh_pkg::CMD_QUERY, random_key());
    end
  endtask

  // Phase: probes, filter size and word count; the phase number picks the flow-control pattern.
  task automatic run_phase(int ph, logic [bfdh_pkg::NH_W-1:0] nh,
                           logic [bfdh_pkg::FB_W-1:0] fb, int count);
    drain();
    repeat (SETTLE_CYC) @(posedge clk);
    write_reg(bfdh_pkg::CFG_NUM_HASHES, bfdh_pkg::CFG_DATA_W'(nh));
    write_reg(bfdh_pkg::CFG_FILTER_BITS, bfdh_pkg::CFG_DATA_W'(fb));
    case (ph % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 75; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 75; end
      default: begin idle_pct = 8; stall_pct = 8; end
    endcase
    random_words(count);
  endtask

  initial begin
    logic [255:0] k;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed words at the reset settings: extreme keys, both commands.
    send_word(bfdh_pkg::CMD_ADD, '0);
    send_word(bfdh_pkg::CMD_ADD, '1);
    send_word(bfdh_pkg::CMD_QUERY, '0);
    send_word(bfdh_pkg::CMD_QUERY, '1);
    send_word(bfdh_pkg::CMD_QUERY, {4{64'h5555_5555_5555_5555}});
    send_word(bfdh_pkg::CMD_QUERY, {4{64'hAAAA_AAAA_AAAA_AAAA}});
    k = random_key();
    send_word(bfdh_pkg::CMD_ADD, k);
    // The top key word lies beyond the key length and must not matter.
    send_word(bfdh_pkg::CMD_QUERY, {~k[255:192], k[191:0]});
    send_word(bfdh_pkg::CMD_QUERY, {k[255:1], ~k[0]});

    // Zero probes: adds only count, queries always hit.
    drain();
    repeat (SETTLE_CYC) @(posedge clk);
    write_reg(bfdh_pkg::CFG_NUM_HASHES, '0);
    send_word(bfdh_pkg::CMD_ADD, random_key());
    send_word(bfdh_pkg::CMD_QUERY, random_key());

    // Size zero acts as one bit; oversize clamps to the full store.
    drain();
    repeat (SETTLE_CYC) @(posedge clk);
    write_reg(bfdh_pkg::CFG_NUM_HASHES, bfdh_pkg::CFG_DATA_W'(3));
    write_reg(bfdh_pkg::CFG_FILTER_BITS, '0);
    send_word(bfdh_pkg::CMD_QUERY, random_key());
    send_word(bfdh_pkg::CMD_ADD, random_key());
    send_word(bfdh_pkg::CMD_QUERY, random_key());
    drain();
    repeat (SETTLE_CYC) @(posedge clk);
    write_reg(bfdh_pkg::CFG_FILTER_BITS, '1);
    send_word(bfdh_pkg::CMD_QUERY, '1);
    send_word(bfdh_pkg::CMD_QUERY, random_key());

    // Random phases over several settings and flow-control patterns.
    run_phase(0, 8'd7,   21'd1048576, 70);
    run_phase(1, 8'd1,   21'd1,       40);
    run_phase(2, 8'd4,   21'd64,      60);
    run_phase(3, 8'd255, 21'h1FFFFF,  25);
    run_phase(4, 8'd12,  21'd1000,    60);
    run_phase(5, 8'd0,   21'd777777,  30);
    run_phase(6, 8'd5,   21'd8,       50);
    run_phase(7, 8'd9,   21'd1048575, 60);
    run_phase(8, 8'd2,   21'd100,     50);

    drain();
    repeat (SETTLE_CYC) @(posedge clk);
    $display("Covered %0d result words (%0d hits) over nine filter settings,", sb.checked,
             sb.hits);
    $display("including zero probes, size zero, oversize and 255 probes under stalls.");
    if (sb.fail_count == 0 && sb.pending_answers.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
